@@ rtl/core/ttag_pkg.sv @@
`default_nettype none
package ttag_pkg;

	// defaults for the top level parameters
	localparam int DEF_RANK          = 4;
	localparam int DEF_MAX_AXIS_SIZE = 16;
	localparam int DEF_ELEMENT_BITS  = 32;

	// fixed field widths
	localparam int AXES       = 4;   // fields of the axis order register
	localparam int FIELD_W    = 2;   // one axis number
	localparam int STEP_W     = 2;   // counts over the axis order fields
	localparam int DIGIT_W    = 4;
	localparam int SIZE_W     = 5;
	localparam int ORDER_W    = 8;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 32;
	localparam int S_TDATA_W  = DATA_W;
	localparam int M_TDATA_W  = DATA_W + ADDR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ORDER_W;

	// register reset values
	localparam logic [SIZE_W-1:0]  RST_SIZE_AXIS0 = 5'd1;
	localparam logic [SIZE_W-1:0]  RST_SIZE_AXIS1 = 5'd2;
	localparam logic [SIZE_W-1:0]  RST_SIZE_AXIS2 = 5'd3;
	localparam logic [SIZE_W-1:0]  RST_SIZE_AXIS3 = 5'd4;
	localparam logic [ORDER_W-1:0] RST_AXIS_ORDER = 8'd27;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} state_t;

	// configuration as the datapath sees it
	typedef struct packed {
		logic [AXES-1:0][SIZE_W-1:0] eff_size;
		logic [ORDER_W-1:0]          axis_order;
	} cfg_view_t;

	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic last_step;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/ttag_config_regs.sv @@
`default_nettype none
module ttag_config_regs #(
	parameter int RANK          = ttag_pkg::DEF_RANK,
	parameter int MAX_AXIS_SIZE = ttag_pkg::DEF_MAX_AXIS_SIZE
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ttag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ttag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ttag_pkg::cfg_view_t                  view
);
	import ttag_pkg::*;

	logic [SIZE_W-1:0]  size_q [AXES];
	logic [ORDER_W-1:0] order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= RST_SIZE_AXIS0;
			size_q[1] <= RST_SIZE_AXIS1;
			size_q[2] <= RST_SIZE_AXIS2;
			size_q[3] <= RST_SIZE_AXIS3;
			order_q   <= RST_AXIS_ORDER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_AXIS0: size_q[0] <= cfg_wdata[SIZE_W-1:0];
				REG_SIZE_AXIS1: size_q[1] <= cfg_wdata[SIZE_W-1:0];
				REG_SIZE_AXIS2: size_q[2] <= cfg_wdata[SIZE_W-1:0];
				REG_SIZE_AXIS3: size_q[3] <= cfg_wdata[SIZE_W-1:0];
				REG_AXIS_ORDER: order_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// zero counts as one, clamp to the largest axis, unused axes have size one
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			if (i >= RANK) begin
				view.eff_size[i] = SIZE_W'(1);
			end else if (size_q[i] == '0) begin
				view.eff_size[i] = SIZE_W'(1);
			end else if (int'(size_q[i]) > MAX_AXIS_SIZE) begin
				view.eff_size[i] = SIZE_W'(MAX_AXIS_SIZE);
			end else begin
				view.eff_size[i] = size_q[i];
			end
		end
		view.axis_order = order_q;
	end

endmodule
`default_nettype wire

@@ rtl/core/ttag_controller.sv @@
`default_nettype none
module ttag_controller (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  ttag_pkg::dp_status_t status,
	output ttag_pkg::dp_cmd_t    cmd
);
	import ttag_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.step = 1'b1;
				if (status.last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/ttag_datapath.sv @@
`default_nettype none
module ttag_datapath #(
	parameter int RANK         = ttag_pkg::DEF_RANK,
	parameter int ELEMENT_BITS = ttag_pkg::DEF_ELEMENT_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  ttag_pkg::cfg_view_t                 cfg,
	input  ttag_pkg::dp_cmd_t                   cmd,
	output ttag_pkg::dp_status_t                status,
	input  wire logic [ttag_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [ttag_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast,
	output logic                                m_tuser
);
	import ttag_pkg::*;

	localparam int EW = (ELEMENT_BITS < DATA_W) ? ELEMENT_BITS : DATA_W;

	// odometer
	logic [DIGIT_W-1:0] digits_q [RANK];
	logic [DIGIT_W-1:0] cur      [AXES];
	logic [DIGIT_W-1:0] nxt      [AXES];
	logic [AXES-1:0]    at_last;
	logic               all_last;
	logic               carry;

	// work registers of the item in flight
	logic [EW-1:0]      elem_q;
	logic               done_q;
	logic               bad_q;
	logic [DIGIT_W-1:0] dig_q [AXES];
	logic [ADDR_W-1:0]  acc_q;
	logic [ADDR_W-1:0]  stride_q;
	logic [STEP_W-1:0]  step_q;

	// output slot
	logic [EW-1:0]      out_bits_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_done_q;
	logic               out_err_q;
	logic               out_valid_q;

	logic                   bad;
	logic [AXES-1:0]        seen;
	logic [FIELD_W-1:0]     pj;
	logic [FIELD_W-1:0]     p;
	logic [DIGIT_W+ADDR_W-1:0] prod;
	logic [SIZE_W+ADDR_W-1:0]  sprod;

	genvar g;
	generate
		for (g = 0; g < AXES; g++) begin : g_axis
			if (g < RANK) begin : g_used
				assign cur[g] = s_tuser ? '0 : digits_q[g];
			end else begin : g_unused
				assign cur[g] = '0;
			end
			assign at_last[g] = ({1'b0, cur[g]} + 5'd1) >= cfg.eff_size[g];
		end
	endgenerate

	// innermost axis counts fastest
	always_comb begin
		carry    = 1'b1;
		all_last = 1'b1;
		for (int i = AXES - 1; i >= 0; i--) begin
			nxt[i] = cur[i];
			if (i < RANK) begin
				if (carry) begin
					nxt[i] = at_last[i] ? '0 : cur[i] + DIGIT_W'(1);
				end
				carry    = carry & at_last[i];
				all_last = all_last & at_last[i];
			end
		end
	end

	// a permutation names every used axis once
	always_comb begin
		bad  = 1'b0;
		seen = '0;
		pj   = '0;
		for (int j = 0; j < AXES; j++) begin
			if (j < RANK) begin
				pj = cfg.axis_order[FIELD_W*j +: FIELD_W];
				if (int'(pj) >= RANK || seen[pj]) begin
					bad = 1'b1;
				end else begin
					seen[pj] = 1'b1;
				end
			end
		end
	end

	// one output axis per step, from the innermost out
	assign p     = cfg.axis_order[FIELD_W*step_q +: FIELD_W];
	assign prod  = (DIGIT_W+ADDR_W)'(dig_q[p]) * (DIGIT_W+ADDR_W)'(stride_q);
	assign sprod = (SIZE_W+ADDR_W)'(stride_q) * (SIZE_W+ADDR_W)'(cfg.eff_size[p]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RANK; i++) begin
				digits_q[i] <= '0;
			end
		end else if (cmd.load) begin
			for (int i = 0; i < RANK; i++) begin
				digits_q[i] <= nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= STEP_W'(RANK - 1);
		end else if (cmd.step) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			elem_q   <= s_tdata[EW-1:0];
			done_q   <= all_last;
			bad_q    <= bad;
			dig_q    <= cur;
			acc_q    <= '0;
			stride_q <= ADDR_W'(1);
		end else if (cmd.step) begin
			acc_q    <= acc_q + prod[ADDR_W-1:0];
			stride_q <= sprod[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_bits_q <= elem_q;
			out_addr_q <= bad_q ? '0 : acc_q;
			out_done_q <= done_q;
			out_err_q  <= bad_q;
		end
	end

	assign status.last_step = (step_q == '0);
	assign status.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_addr_q, DATA_W'(out_bits_q)};
	assign m_tlast  = out_done_q;
	assign m_tuser  = out_err_q;

endmodule
`default_nettype wire

@@ rtl/core/tensor_transpose_address_gen.sv @@
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: element_bits[31:0]; tuser: restart
// m_*       out  m_tvalid/m_tready  tdata: moved_bits[31:0], dest_address[47:32];
//                                   tlast: tensor_done; tuser: order_error
// cfg_*     in   cfg_we             cfg_index selects the register, cfg_wdata the value
//
// each element passes through the transfer, RANK multiply-add steps of the
// shared address accumulator (one output axis each), and the hand-off into the output slot
// the output slot is its own register, so a new element is taken while a result waits
// a result that finds the slot full holds in the datapath until the slot is freed
// reset clears the position counter, the sequencer and the output valid;
// the registers come up as sizes 1, 2, 3, 4 and axis order 27
`default_nettype none
module tensor_transpose_address_gen #(
	parameter int RANK          = ttag_pkg::DEF_RANK,
	parameter int MAX_AXIS_SIZE = ttag_pkg::DEF_MAX_AXIS_SIZE,
	parameter int ELEMENT_BITS  = ttag_pkg::DEF_ELEMENT_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ttag_pkg::S_TDATA_W-1:0]  s_tdata,   // element_bits
	input  wire logic                            s_tuser,   // restart
	// output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ttag_pkg::M_TDATA_W-1:0]       m_tdata,   // moved_bits, dest_address
	output logic                                 m_tlast,   // tensor_done
	output logic                                 m_tuser,   // order_error
	// register writes
	input  wire logic                            cfg_we,
	input  wire logic [ttag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ttag_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ttag_pkg::*;

	cfg_view_t  cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// sizes are clamped here so the datapath sees legal values only
	ttag_config_regs #(
		.RANK          (RANK),
		.MAX_AXIS_SIZE (MAX_AXIS_SIZE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.view      (cfg)
	);

	// sequencer: idle, accumulate over axes, hand off to the output slot
	ttag_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// odometer advances on the transfer; the address is built from the snapshot
	ttag_datapath #(
		.RANK         (RANK),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

@@ rtl/core/ttag_checker.sv @@
`default_nettype none
module ttag_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [ttag_pkg::M_TDATA_W-1:0]  m_tdata,
	input wire logic                            m_tlast,
	input wire logic                            m_tuser
);
	import ttag_pkg::*;

	// a stalled result keeps its valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// a bad axis order gives address zero
	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[M_TDATA_W-1:DATA_W] == '0)
		else $error("nonzero address with order error");

	// one element in flight: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// a result never appears in the cycle after its element is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early after input transfer");

endmodule

bind tensor_transpose_address_gen ttag_checker u_ttag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.m_tuser   (m_tuser)
);
`default_nettype wire

@@ dv/tensor_transpose_address_gen_tb.sv @@
module tensor_transpose_address_gen_tb;
	import ttag_pkg::*;

	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off for back-pressure
	localparam int STALL_LIMIT   = 5000;  // cycles with no transfer before giving up
	localparam int SETTLE_CYCLES = 8;     // idle margin once every placement came out
	localparam int PHASE_ITEMS   = 60;

	// one element as offered on the input stream
	typedef struct packed {
		logic [DATA_W-1:0] bits;
		logic              restart;
	} element_t;

	// one placed element as it should leave the block
	typedef struct packed {
		logic [DATA_W-1:0] moved_bits;
		logic [ADDR_W-1:0] dest_address;
		logic              tensor_done;
		logic              order_error;
	} placement_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;    // element_bits
	logic                  s_tuser   = 1'b0;  // restart
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;           // moved_bits, dest_address
	logic                  m_tlast;           // tensor_done
	logic                  m_tuser;           // order_error
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	tensor_transpose_address_gen DUT (.*);

	// shadow of the register file and the position counter
	logic [SIZE_W-1:0]  size_shadow [AXES] = '{RST_SIZE_AXIS0, RST_SIZE_AXIS1,
		RST_SIZE_AXIS2, RST_SIZE_AXIS3};
	logic [ORDER_W-1:0] order_shadow = RST_AXIS_ORDER;
	logic [DIGIT_W-1:0] digit_shadow [AXES] = '{default: '0};

	element_t   pending [$];     // elements waiting to be offered
	placement_t placements [$];  // expected output transfers, oldest first
	element_t   next_item;
	placement_t want;
	placement_t got;

	int accepted_elements = 0;   // input transfers so far, updated by the driver only
	int send_idle_pct     = 0;
	int recv_idle_pct     = 0;
	int hold_at           = -1;  // input transfer count at which the receiver holds off
	int hold_done         = -1;
	int hold_left         = 0;
	int quiet_cycles      = 0;
	int failures          = 0;

	initial forever #5 clk = ~clk;

	// size as the datapath uses it: zero reads as one, clipped at the maximum
	function automatic int unsigned axis_span(int axis);
		int unsigned s;
		if (axis >= DEF_RANK) return 1;
		s = size_shadow[axis];
		if (s == 0) s = 1;
		if (s > DEF_MAX_AXIS_SIZE) s = DEF_MAX_AXIS_SIZE;
		return s;
	endfunction

	// destination of one element in the transposed tensor, then odometer advance
	function automatic placement_t place_element(element_t e);
		placement_t      r;
		logic [AXES-1:0] seen;
		logic            bad;
		logic            carry;
		int unsigned     addr;
		int unsigned     stride;
		int unsigned     p;
		if (e.restart) foreach (digit_shadow[i]) digit_shadow[i] = '0;
		seen = '0;
		bad  = 1'b0;
		for (int j = 0; j < DEF_RANK; j++) begin
			p = order_shadow[FIELD_W*j +: FIELD_W];
			if (p >= DEF_RANK || seen[p]) bad = 1'b1;
			else seen[p] = 1'b1;
		end
		// output axis j takes input axis p; innermost output axis has stride one
		addr   = 0;
		stride = 1;
		if (!bad) begin
			for (int j = DEF_RANK - 1; j >= 0; j--) begin
				p = order_shadow[FIELD_W*j +: FIELD_W];
				addr   += digit_shadow[p] * stride;
				stride *= axis_span(p);
			end
		end
		// a digit at or past its size counts as the last position
		r.tensor_done = 1'b1;
		for (int i = 0; i < DEF_RANK; i++)
			if (digit_shadow[i] + 1 < axis_span(i)) r.tensor_done = 1'b0;
		carry = 1'b1;
		for (int i = DEF_RANK - 1; i >= 0; i--) begin
			if (carry) begin
				if (digit_shadow[i] + 1 < axis_span(i)) begin
					digit_shadow[i] = digit_shadow[i] + 1'b1;
					carry = 1'b0;
				end else begin
					digit_shadow[i] = '0;
				end
			end
		end
		r.moved_bits   = e.bits;
		r.dest_address = ADDR_W'(addr);
		r.order_error  = bad;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [DATA_W-1:0] exp_val,
		logic [DATA_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
			failures++;
		end
	endfunction

	// driver: predicts on every input transfer, refills the slot from the queue
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			placements.push_back(place_element('{s_tdata, s_tuser}));
			accepted_elements <= accepted_elements + 1;
		end
		if (!s_tvalid || s_tready) begin
			if (arst_n && pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_item = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_item.bits;
				s_tuser  <= next_item.restart;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: checks every output transfer and drives the receiver's ready
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (placements.size() == 0) begin
				$error("output transfer with nothing expected: tdata %0h", m_tdata);
				failures++;
			end else begin
				want = placements.pop_front();
				got  = '{m_tdata[DATA_W-1:0], m_tdata[DATA_W +: ADDR_W], m_tlast, m_tuser};
				compare_field("moved_bits", want.moved_bits, got.moved_bits);
				compare_field("dest_address", DATA_W'(want.dest_address),
					DATA_W'(got.dest_address));
				compare_field("tensor_done", DATA_W'(want.tensor_done), DATA_W'(got.tensor_done));
				compare_field("order_error", DATA_W'(want.order_error), DATA_W'(got.order_error));
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_at >= 0 && accepted_elements == hold_at && hold_done != hold_at) begin
			// hold off long enough that the block backs up and drops s_tready
			m_tready  <= 1'b0;
			hold_left = HOLD_CYCLES;
			hold_done = hold_at;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tensor_transpose_address_gen regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// wait until every element went in and every placement came out
	task automatic settle();
		forever begin
			@(negedge clk);
			if (pending.size() == 0 && !s_tvalid && placements.size() == 0) break;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// rewrite all five registers while the block is idle
	task automatic program_axes(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
		input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
		input logic [ORDER_W-1:0] order);
		logic [CFG_IDX_W-1:0]  idx [5];
		logic [CFG_DATA_W-1:0] val [5];
		idx = '{REG_SIZE_AXIS0, REG_SIZE_AXIS1, REG_SIZE_AXIS2, REG_SIZE_AXIS3, REG_AXIS_ORDER};
		val = '{CFG_DATA_W'(s0), CFG_DATA_W'(s1), CFG_DATA_W'(s2), CFG_DATA_W'(s3), order};
		settle();
		for (int r = 0; r < 5; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[r];
			cfg_wdata <= val[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		size_shadow  = '{s0, s1, s2, s3};
		order_shadow = order;
		@(negedge clk);
	endtask

	function automatic void offer(logic [DATA_W-1:0] bits, logic restart);
		pending.push_back('{bits, restart});
	endfunction

	// mostly small axes so tensors complete often, sometimes out of range or full size
	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return SIZE_W'($urandom_range(17, 31));
		if (r < 15) return SIZE_W'(DEF_MAX_AXIS_SIZE);
		return SIZE_W'($urandom_range(1, 4));
	endfunction

	// mostly a true permutation, sometimes any byte (usually a bad one)
	function automatic logic [ORDER_W-1:0] pick_order();
		logic [FIELD_W-1:0] axis [AXES];
		logic [FIELD_W-1:0] t;
		logic [ORDER_W-1:0] o;
		int                 k;
		if ($urandom_range(0, 99) < 20) return ORDER_W'($urandom_range(0, 255));
		foreach (axis[i]) axis[i] = FIELD_W'(i);
		for (int i = AXES - 1; i > 0; i--) begin
			k       = $urandom_range(0, i);
			t       = axis[i];
			axis[i] = axis[k];
			axis[k] = t;
		end
		foreach (axis[i]) o[FIELD_W*i +: FIELD_W] = axis[i];
		return o;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register values straight out of reset
		offer(32'h0000_0000, 1'b0);
		offer(32'hFFFF_FFFF, 1'b0);
		offer(32'hA5A5_5A5A, 1'b0);

		// four-element tensor, full reversal: done flag and wrap
		program_axes(5'd2, 5'd1, 5'd1, 5'd2, RST_AXIS_ORDER);
		offer(32'h0000_0000, 1'b1);
		offer(32'hFFFF_FFFF, 1'b0);
		offer(32'h8000_0001, 1'b0);
		offer(32'h7FFF_FFFE, 1'b0);
		offer(32'h1234_5678, 1'b0);

		// sizes of zero and above the maximum, identity order
		program_axes(5'd0, 5'd31, 5'd1, 5'd17, 8'b11_10_01_00);
		offer(32'hDEAD_BEEF, 1'b1);
		offer(32'h0F0F_0F0F, 1'b0);
		offer(32'hF0F0_F0F0, 1'b0);

		// axis order that is not a permutation
		program_axes(5'd1, 5'd2, 5'd3, 5'd4, 8'h00);
		offer(32'h5555_5555, 1'b1);
		offer(32'hAAAA_AAAA, 1'b0);
		offer(32'h0000_0001, 1'b0);

		// walk the innermost digit up, then shrink its axis below it
		program_axes(5'd1, 5'd1, 5'd1, 5'd16, RST_AXIS_ORDER);
		for (int i = 0; i < 6; i++) offer($urandom, i == 0);
		program_axes(5'd1, 5'd1, 5'd1, 5'd3, RST_AXIS_ORDER);
		for (int i = 0; i < 3; i++) offer($urandom, 1'b0);

		// random part: receiver-heavy idling, then sender-heavy, then none
		for (int mode = 0; mode < 3; mode++) begin
			for (int ph = 0; ph < 6; ph++) begin
				if (ph == 0 && mode == 0)
					program_axes(5'd31, 5'd31, 5'd31, 5'd31, 8'b11_10_01_00);
				else if (ph == 0 && mode == 1)
					program_axes(5'd1, 5'd1, 5'd1, 5'd1, 8'hFF);
				else if (ph == 0)
					program_axes(5'd16, 5'd16, 5'd16, 5'd16, RST_AXIS_ORDER);
				else
					program_axes(pick_size(), pick_size(), pick_size(), pick_size(), pick_order());
				send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 48 : 0;
				recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 26 : 0;
				if (mode == 0 && ph == 2) hold_at = accepted_elements + 10;
				// most phases start a fresh tensor, a few restarts land mid-tensor
				for (int i = 0; i < PHASE_ITEMS; i++)
					offer($urandom, (i == 0) ? ($urandom_range(0, 99) < 70)
						: ($urandom_range(0, 99) < 2));
			end
		end

		settle();
		if (failures == 0)
			$display("tensor_transpose_address_gen regression: pass");
		else
			$display("tensor_transpose_address_gen regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ttag_pkg.sv
rtl/core/ttag_config_regs.sv
rtl/core/ttag_controller.sv
rtl/core/ttag_datapath.sv
rtl/core/tensor_transpose_address_gen.sv
rtl/core/ttag_checker.sv
dv/tensor_transpose_address_gen_tb.sv
